@@ rtl/core/sobel_edge_magnitude_top_defines.svh @@
// Assertion macros for the edge magnitude block.
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH

// Check a property outside reset.
`define SEM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define SEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sem_pkg.sv @@
`timescale 1ns / 1ps
package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef logic [7:0]          pix_t;
  typedef logic [10:0]         col_t;
  typedef logic [11:0]         row_t;
  typedef logic [11:0]         img_w_t;
  typedef logic [12:0]         img_h_t;
  typedef logic signed [8:0]   grad_t;
  typedef logic [1:0]          cfg_idx_t;
  typedef logic [12:0]         cfg_data_t;
  typedef logic [Q_CNT_W-1:0]  q_cnt_t;
  typedef logic [Q_PTR_W-1:0]  q_ptr_t;

  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;

  localparam img_w_t IMG_W_RST = 12'd640;
  localparam img_h_t IMG_H_RST = 13'd480;
  localparam img_w_t IMG_W_MAX = img_w_t'(MAX_WIDTH);
  localparam img_h_t IMG_H_MAX = img_h_t'(MAX_HEIGHT);
  localparam pix_t   MAG_SAT   = 8'hFF;

  typedef struct packed {
    grad_t sx;
    grad_t sy;
    col_t  ccol;
    row_t  crow;
    logic  last;
  } sem_item_t;

  typedef struct packed {
    logic      valid;
    sem_item_t item;
  } sem_qhead_t;

endpackage

@@ rtl/core/sem_ifs.sv @@
`timescale 1ns / 1ps
interface sem_pix_if import sem_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;
  logic frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sem_res_if import sem_pkg::*; ();
  logic valid;
  logic ready;
  pix_t magnitude;
  col_t center_col;
  row_t center_row;
  logic frame_last;
  modport source (output valid, output magnitude, output center_col, output center_row,
                  output frame_last, input ready);
  modport sink (input valid, input magnitude, input center_col, input center_row,
                input frame_last, output ready);
endinterface

interface sem_cfg_if import sem_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/sem_front.sv @@
`timescale 1ns / 1ps
module sem_front import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sem_pix_if.sink   in_ch,
  input  img_w_t    img_w,
  input  img_h_t    img_h,
  input  q_cnt_t    q_free,
  output logic      push_valid,
  output sem_item_t push_item
);

  logic   acc;
  col_t   col_cur;
  row_t   row_cur;
  img_w_t w_eff;
  img_h_t h_eff;
  col_t   col_cnt_r, col_cnt_nxt;
  row_t   row_cnt_r, row_cnt_nxt;

  logic   s1_valid_r;
  pix_t   s1_px_r;
  col_t   s1_col_r;
  row_t   s1_row_r;

  pix_t   line_a_r [MAX_WIDTH];
  pix_t   line_b_r [MAX_WIDTH];
  pix_t   rd_a_r, rd_b_r;
  logic   fwd_hit_r;
  pix_t   fwd_a_r, fwd_b_r;
  pix_t   eff_a, eff_b;

  pix_t   win_r [3][3];
  pix_t   win_nxt [3][3];
  logic signed [11:0] gx, gy;
  logic   hit;

  function automatic logic signed [11:0] ext(input pix_t p);
    return $signed({4'b0000, p});
  endfunction

  assign in_ch.ready = q_free > q_cnt_t'(s1_valid_r);
  assign acc         = in_ch.valid && in_ch.ready;
  assign w_eff       = (img_w > IMG_W_MAX) ? IMG_W_MAX : img_w;
  assign h_eff       = (img_h > IMG_H_MAX) ? IMG_H_MAX : img_h;
  assign col_cur     = in_ch.frame_start ? '0 : col_cnt_r;
  assign row_cur     = in_ch.frame_start ? '0 : row_cnt_r;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (acc) begin
      if (({1'b0, col_cur} + 12'd1) >= w_eff) begin
        col_cnt_nxt = '0;
        if (({1'b0, row_cur} + 13'd1) >= h_eff) begin
          row_cnt_nxt = '0;
        end else begin
          row_cnt_nxt = row_cur + 12'd1;
        end
      end else begin
        col_cnt_nxt = col_cur + 11'd1;
        row_cnt_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= acc;
      fwd_hit_r  <= acc && s1_valid_r && (s1_col_r == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r  <= in_ch.pixel;
      s1_col_r <= col_cur;
      s1_row_r <= row_cur;
      fwd_a_r  <= s1_px_r;
      fwd_b_r  <= eff_a;
    end
  end

  // read-modify-write of both line stores; forward the write of the previous request
  assign eff_a = fwd_hit_r ? fwd_a_r : rd_a_r;
  assign eff_b = fwd_hit_r ? fwd_b_r : rd_b_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_a_r <= line_a_r[col_cur];
      rd_b_r <= line_b_r[col_cur];
    end
    if (s1_valid_r) begin
      line_a_r[s1_col_r] <= s1_px_r;
      line_b_r[s1_col_r] <= eff_a;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = eff_b;
    win_nxt[1][2] = eff_a;
    win_nxt[2][2] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  assign gx = ext(win_nxt[0][0]) + (ext(win_nxt[1][0]) <<< 1) + ext(win_nxt[2][0])
            - ext(win_nxt[0][2]) - (ext(win_nxt[1][2]) <<< 1) - ext(win_nxt[2][2]);
  assign gy = ext(win_nxt[2][0]) + (ext(win_nxt[2][1]) <<< 1) + ext(win_nxt[2][2])
            - ext(win_nxt[0][0]) - (ext(win_nxt[0][1]) <<< 1) - ext(win_nxt[0][2]);

  assign hit = (w_eff >= 12'd3) && (h_eff >= 13'd3)
            && (s1_col_r >= 11'd2) && (s1_row_r >= 12'd2)
            && ({1'b0, s1_col_r} < w_eff) && ({1'b0, s1_row_r} < h_eff);

  assign push_valid     = s1_valid_r && hit;
  assign push_item.sx   = grad_t'(gx >>> 2);
  assign push_item.sy   = grad_t'(gy >>> 2);
  assign push_item.ccol = s1_col_r - 11'd1;
  assign push_item.crow = s1_row_r - 12'd1;
  assign push_item.last = ({1'b0, s1_col_r} == (w_eff - 12'd1))
                       && ({1'b0, s1_row_r} == (h_eff - 13'd1));

endmodule

@@ rtl/core/sem_queue.sv @@
`timescale 1ns / 1ps
module sem_queue import sem_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  sem_item_t  push_item,
  input  logic       pop,
  output sem_qhead_t head,
  output q_cnt_t     q_free
);

  sem_item_t ent_r [Q_DEPTH];
  q_ptr_t    wr_ptr_r, rd_ptr_r;
  q_cnt_t    cnt_r, cnt_nxt;

  assign head.valid = cnt_r != '0;
  assign head.item  = ent_r[rd_ptr_r];
  assign q_free     = q_cnt_t'(Q_DEPTH) - cnt_r;

  always_comb begin
    case ({push_valid, pop})
      2'b10:   cnt_nxt = cnt_r + q_cnt_t'(1);
      2'b01:   cnt_nxt = cnt_r - q_cnt_t'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + q_ptr_t'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + q_ptr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/sem_back.sv @@
`timescale 1ns / 1ps
module sem_back import sem_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sem_qhead_t head,
  output logic       pop,
  sem_res_if.source  out_ch
);

  localparam int SQ_STAGES = 4;

  typedef struct packed {
    logic        valid;
    logic [15:0] qx;
    logic [15:0] qy;
    col_t        ccol;
    row_t        crow;
    logic        last;
  } sq_in_t;

  typedef struct packed {
    logic        valid;
    logic        sat;
    logic [15:0] rad;
    logic [9:0]  rem;
    pix_t        root;
    col_t        ccol;
    row_t        crow;
    logic        last;
  } sq_st_t;

  function automatic sq_st_t sq_step(input sq_st_t st);
    sq_st_t      nx;
    logic [11:0] rem_w;
    logic [11:0] trial;
    nx    = st;
    rem_w = {st.rem, st.rad[15:14]};
    trial = {2'b00, st.root, 2'b01};
    nx.rad = {st.rad[13:0], 2'b00};
    if (rem_w >= trial) begin
      nx.rem  = 10'(rem_w - trial);
      nx.root = {st.root[6:0], 1'b1};
    end else begin
      nx.rem  = rem_w[9:0];
      nx.root = {st.root[6:0], 1'b0};
    end
    return nx;
  endfunction

  logic               adv;
  logic signed [17:0] px2, py2;
  logic [16:0]        sum;
  sq_in_t             p0_r;
  sq_st_t             st_r [SQ_STAGES + 1];
  logic               out_valid_r;
  pix_t               mag_r;
  col_t               ccol_r;
  row_t               crow_r;
  logic               last_r;

  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head.valid;

  assign px2 = head.item.sx * head.item.sx;
  assign py2 = head.item.sy * head.item.sy;
  assign sum = {1'b0, p0_r.qx} + {1'b0, p0_r.qy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= SQ_STAGES; i++) begin
        st_r[i] <= '0;
      end
    end else if (adv) begin
      p0_r.valid <= pop;
      p0_r.qx    <= px2[15:0];
      p0_r.qy    <= py2[15:0];
      p0_r.ccol  <= head.item.ccol;
      p0_r.crow  <= head.item.crow;
      p0_r.last  <= head.item.last;

      st_r[0].valid <= p0_r.valid;
      st_r[0].sat   <= sum[16];
      st_r[0].rad   <= sum[15:0];
      st_r[0].rem   <= '0;
      st_r[0].root  <= '0;
      st_r[0].ccol  <= p0_r.ccol;
      st_r[0].crow  <= p0_r.crow;
      st_r[0].last  <= p0_r.last;

      for (int i = 0; i < SQ_STAGES; i++) begin
        st_r[i + 1] <= sq_step(sq_step(st_r[i]));
      end

      out_valid_r <= st_r[SQ_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_r[SQ_STAGES].valid) begin
      mag_r  <= st_r[SQ_STAGES].sat ? MAG_SAT : st_r[SQ_STAGES].root;
      ccol_r <= st_r[SQ_STAGES].ccol;
      crow_r <= st_r[SQ_STAGES].crow;
      last_r <= st_r[SQ_STAGES].last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.magnitude  = mag_r;
  assign out_ch.center_col = ccol_r;
  assign out_ch.center_row = crow_r;
  assign out_ch.frame_last = last_r;

endmodule

@@ rtl/core/sobel_edge_magnitude_top.sv @@
`timescale 1ns / 1ps
// channel | dir | payload                                          | request accepted
// in_ch   | in  | pixel[7:0], frame_start                          | valid && ready
// out_ch  | out | magnitude[7:0], center_col[10:0], center_row[11:0], frame_last
//         |     |                                                  | valid && ready
// cfg_ch  | in  | index[1:0], data[12:0]                           | valid && ready
//
// One pixel request per clock while in_ch.ready is high; the line store read-modify-write
// runs in two stages with write forwarding, so back-to-back requests on one column keep pace.
// A result passes the s1 registers, the queue, p0_r, st_r[0] and the square-root stages to the
// out_ch register; the square root takes two bits per stage over four stages.
// Reset clears counters, window, queue and pipeline; line stores are not cleared.
// An out_ch stall holds the back pipeline; the 4-entry queue then fills and in_ch.ready drops.
module sobel_edge_magnitude_top import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sem_pix_if.sink   in_ch,
  sem_res_if.source out_ch,
  sem_cfg_if.sink   cfg_ch
);

  img_w_t     img_w_r;
  img_h_t     img_h_r;
  logic       push_valid;
  sem_item_t  push_item;
  logic       pop;
  sem_qhead_t head;
  q_cnt_t     q_free;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RST;
      img_h_r <= IMG_H_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_ch.data[11:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  sem_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .img_w      (img_w_r),
    .img_h      (img_h_r),
    .q_free     (q_free),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  sem_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .q_free     (q_free)
  );

  sem_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

@@ rtl/core/sem_checker.sv @@
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_top_defines.svh"
module sem_out_checker import sem_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input col_t center_col,
  input row_t center_row,
  input logic frame_last
);

  logic [23:0] out_tag;

  assign out_tag = {center_col, center_row, frame_last};

  `SEM_ASSERT_ALWAYS(a_rst_out_idle, clk, !rst_n |=> !out_valid, "out valid after reset")
  `SEM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out dropped")
  `SEM_ASSERT(a_no_border, clk, rst_n, out_valid |-> |center_col && |center_row, "border result")
  `SEM_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_tag), "out moved")

endmodule

bind sobel_edge_magnitude_top sem_out_checker u_sem_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .center_col (out_ch.center_col),
  .center_row (out_ch.center_row),
  .frame_last (out_ch.frame_last)
);
